### rtl/pvmf_pkg.sv
// ----------------------------------------------------------------------------
// pvmf_pkg: shared types and constants of the port vlan membership filter
// item and table entry layouts, command, verdict and register codes,
// and the per-command result rule
// ----------------------------------------------------------------------------
package pvmf_pkg;

    localparam int VID_W   = 12;
    localparam int CNT_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 12;

    // command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_INGRESS = 2'd1;
    localparam logic [1:0] CMD_EGRESS  = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    // verdict codes
    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_VALID = 2'd1;
    localparam logic [1:0] VERDICT_DROP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_BRIDGE_PRESENT    = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_FILTERING_ENABLED = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_PROTO_IS_AD       = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_PORT_DEFAULT_VID  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ENTRY_COUNT       = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_TABLE_PRESENT     = 3'd5;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [VID_W-1:0]  vlan_id;
        logic              tag_present;
        logic              tag_is_ad;
        logic [SLOT_W-1:0] entry_index;
        logic              entry_untagged;
        logic              entry_forwarding;
        logic              entry_tunnel;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       verdict;
        logic [VID_W-1:0] result_vid;
        logic             out_tag_present;
        logic             out_tag_is_ad;
        logic             is_forwarding;
        logic             has_tunnel;
    } t_out_item;

    // one membership table slot
    typedef struct packed {
        logic             tunnel;
        logic             forwarding;
        logic             untagged;
        logic [VID_W-1:0] vid;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // result of one command given the lookup outcome
    function automatic t_out_item f_result(
        input logic [1:0]       cmd,
        input logic             bpfe,
        input logic             tbl,
        input logic             proto,
        input logic             drop_now,
        input logic [VID_W-1:0] want,
        input logic             hit,
        input t_entry           ent
    );
        t_out_item res;
        res = '0;
        unique case (cmd)
            CMD_WRITE: begin
                res = '0;
            end
            CMD_INGRESS: begin
                if (bpfe) begin
                    if (!drop_now && hit) begin
                        res.verdict    = VERDICT_VALID;
                        res.result_vid = want;
                    end else begin
                        res.verdict = VERDICT_DROP;
                    end
                end
            end
            CMD_EGRESS: begin
                if (bpfe) begin
                    if (!hit) begin
                        res.verdict = VERDICT_DROP;
                    end else if (!ent.untagged) begin
                        res.verdict         = VERDICT_VALID;
                        res.result_vid      = want;
                        res.out_tag_present = 1'b1;
                        res.out_tag_is_ad   = proto;
                    end
                end
            end
            CMD_QUERY: begin
                if (!tbl) begin
                    res.is_forwarding = 1'b1;
                end else if (hit) begin
                    res.is_forwarding = ent.forwarding;
                    res.has_tunnel    = ent.tunnel;
                end
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

### rtl/port_vlan_membership_filter_unit.sv
// ----------------------------------------------------------------------------
// port_vlan_membership_filter_unit: bridge port vlan membership filter
// holds the port's vlan membership table and answers write, ingress,
// egress and query commands by a sequential scan of the table
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_data): one command per
//   transfer; o_in_stall is high while a command is being worked on
//   output channel (o_out_valid / i_out_stall / o_out_data): exactly one
//   result per command, in command order
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   register writes, always ready; the user must write only while no
//   command is in flight, which the block itself does not enforce
// command flow
//   write, and any command that needs no lookup: the result goes straight
//   to the output register, or the hold register if the receiver stalls;
//   the next command is accepted right away unless that result was parked
//   lookups: one shared 12-bit comparator walks the slots in order, one
//   slot per cycle over the registered-read table memory; a match ends the
//   walk early, and at most min(entry_count, MAX_VLANS) slots are read
// reset: control state and all config registers clear; table contents
//   stay undefined until written, no clearing pass
// receiver stall: a finished result waits in the output register; a second
//   finished result parks in a hold register and the block stalls its input
// ----------------------------------------------------------------------------
module port_vlan_membership_filter_unit
    import pvmf_pkg::*;
#(
    parameter int MAX_VLANS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_A_W-1:0] i_cfg_index,
    input  logic [CFG_D_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_VLANS > 1) ? $clog2(MAX_VLANS) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    // config registers
    logic             r_bridge_present;
    logic             r_filtering_enabled;
    logic             r_proto_is_ad;
    logic [VID_W-1:0] r_port_default_vid;
    logic [CNT_W-1:0] r_entry_count;
    logic             r_table_present;

    // sequencer and command context
    logic [1:0]       r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    logic [VID_W-1:0] r_want, n_want;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    t_out_item        r_hold, n_hold;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             w_accept;
    logic             w_bpfe;
    logic             w_fallback;
    logic             w_drop_now;
    logic [VID_W-1:0] w_want;
    logic [CNT_W-1:0] w_limit;
    logic             w_need_scan;
    t_out_item        w_fixed_res;
    logic             w_out_free;
    logic             w_issue;
    logic             w_hit;
    logic             w_fin;
    t_out_item        w_scan_res;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;
    t_entry           w_wr_entry;
    t_entry           w_rd_entry;

    assign o_cfg_ready = 1'b1;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridge_present    <= 1'b0;
            r_filtering_enabled <= 1'b0;
            r_proto_is_ad       <= 1'b0;
            r_port_default_vid  <= '0;
            r_entry_count       <= '0;
            r_table_present     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BRIDGE_PRESENT:    r_bridge_present    <= i_cfg_data[0];
                REG_FILTERING_ENABLED: r_filtering_enabled <= i_cfg_data[0];
                REG_PROTO_IS_AD:       r_proto_is_ad       <= i_cfg_data[0];
                REG_PORT_DEFAULT_VID:  r_port_default_vid  <= i_cfg_data;
                REG_ENTRY_COUNT:       r_entry_count       <= i_cfg_data[CNT_W-1:0];
                REG_TABLE_PRESENT:     r_table_present     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // command decode at transfer time
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_bpfe     = r_bridge_present && r_filtering_enabled;
    // ingress: untagged or wrong tag kind falls back to the pvid
    assign w_fallback = !i_in_data.tag_present || (i_in_data.tag_is_ad != r_proto_is_ad);
    assign w_want     = ((i_in_data.cmd == CMD_INGRESS) && w_fallback)
                        ? r_port_default_vid : i_in_data.vlan_id;
    assign w_drop_now = (i_in_data.cmd == CMD_INGRESS) && w_fallback
                        && (r_port_default_vid == '0);

    // slots taken into the walk, clamped to the table size
    assign w_limit = ({{(32-CNT_W){1'b0}}, r_entry_count} > 32'(MAX_VLANS))
                     ? CNT_W'(MAX_VLANS) : r_entry_count;

    always_comb begin
        w_need_scan = 1'b0;
        case (i_in_data.cmd)
            CMD_INGRESS: w_need_scan = w_bpfe && !w_drop_now;
            CMD_EGRESS:  w_need_scan = w_bpfe;
            CMD_QUERY:   w_need_scan = r_table_present;
            default:     w_need_scan = 1'b0;
        endcase
        // empty table: nothing to walk, answer as a miss
        if (w_limit == '0) begin
            w_need_scan = 1'b0;
        end
    end

    // answer when no lookup runs (or the lookup cannot hit)
    assign w_fixed_res = f_result(i_in_data.cmd, w_bpfe, r_table_present, r_proto_is_ad,
                                  w_drop_now, w_want, 1'b0, '0);

    // table writes, slots beyond the table size are dropped
    assign w_wr_en = w_accept && (i_in_data.cmd == CMD_WRITE)
                     && ({{(32-SLOT_W){1'b0}}, i_in_data.entry_index} < 32'(MAX_VLANS));

    assign w_wr_entry.tunnel     = i_in_data.entry_tunnel;
    assign w_wr_entry.forwarding = i_in_data.entry_forwarding;
    assign w_wr_entry.untagged   = i_in_data.entry_untagged;
    assign w_wr_entry.vid        = i_in_data.vlan_id;

    generate
        if (AW > SLOT_W) begin : g_wr_wide
            assign w_wr_addr = {{(AW-SLOT_W){1'b0}}, i_in_data.entry_index};
        end else begin : g_wr_narrow
            assign w_wr_addr = i_in_data.entry_index[AW-1:0];
        end
        if (AW > CNT_W) begin : g_rd_wide
            assign w_rd_addr = {{(AW-CNT_W){1'b0}}, r_idx};
        end else begin : g_rd_narrow
            assign w_rd_addr = r_idx[AW-1:0];
        end
    endgenerate

    pvmf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VLANS),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry)
    );

    // walk: issue slot r_idx, compare the slot read last cycle
    assign w_issue    = (r_state == S_SCAN) && (r_idx != r_limit);
    assign w_hit      = r_pend && (w_rd_entry.vid == r_want);
    assign w_fin      = (r_state == S_SCAN) && (w_hit || !w_issue);
    assign w_scan_res = f_result(r_cmd, w_bpfe, r_table_present, r_proto_is_ad,
                                 1'b0, r_want, w_hit, w_rd_entry);

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_want      = r_want;
        n_limit     = r_limit;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_hold      = r_hold;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_in_data.cmd;
                    n_want  = w_want;
                    n_limit = w_limit;
                    n_idx   = '0;
                    if (w_need_scan) begin
                        n_state = S_SCAN;
                    end else if (w_out_free) begin
                        n_out       = w_fixed_res;
                        n_out_valid = 1'b1;
                    end else begin
                        n_hold  = w_fixed_res;
                        n_state = S_HOLD;
                    end
                end
            end
            S_SCAN: begin
                n_pend = w_issue && !w_fin;
                if (w_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (w_fin) begin
                    if (w_out_free) begin
                        n_out       = w_scan_res;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_hold  = w_scan_res;
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_hold;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_limit     <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_limit     <= n_limit;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_want <= n_want;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // walk index never runs past the slot limit
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_limit))
        else $error("scan index beyond limit");

    // a compare only ever sees data from a read issued the cycle before
    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(w_issue))
        else $error("compare without a preceding read");

    // an accepted command either starts work or shows its result
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state != S_IDLE) || o_out_valid))
        else $error("accepted command vanished");

    // the hold register is only used while the output register is occupied
    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> o_out_valid)
        else $error("result parked while output empty");

endmodule

### rtl/pvmf_ram.sv
// ----------------------------------------------------------------------------
// pvmf_ram: generic single-write, single-read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pvmf_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the port vlan membership filter unit
// a driver feeds commands from a queue, a shadow membership table and
// config copy predict each result, and a monitor compares every result
// transfer field by field; directed commands come first, then random phases
// with fresh register settings, random idling and one long receiver hold
// ----------------------------------------------------------------------------
module tb_top;
    import pvmf_pkg::*;

    localparam int N_SLOTS       = 16;
    localparam int N_PHASES      = 16;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 500;
    localparam int DRAIN_CYCLES  = 25;
    localparam int IDLE_PCT      = 34;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           in_data = '0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_A_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0] cfg_data = '0;

    // shadow of the block's registers and membership table
    logic             cfg_bridge = 1'b0;
    logic             cfg_filter = 1'b0;
    logic             cfg_proto_ad = 1'b0;
    logic [VID_W-1:0] cfg_pvid = '0;
    logic [CNT_W-1:0] cfg_count = '0;
    logic             cfg_table = 1'b0;
    t_entry           member_shadow [N_SLOTS];

    t_in_item  cmd_pending [$];
    t_out_item verdict_q [$];
    t_out_item exp_res;

    logic [VID_W-1:0] vid_pool [8];
    bit          calm = 1'b0;
    int unsigned err_count = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned cmd_count [4] = '{0, 0, 0, 0};
    int unsigned verdict_count [3] = '{0, 0, 0};

    port_vlan_membership_filter_unit #(
        .MAX_VLANS(N_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // first slot below the clamped entry count holding this vid, or -1
    function automatic int find_member(logic [VID_W-1:0] vid);
        int n;
        n = (cfg_count > N_SLOTS) ? N_SLOTS : int'(cfg_count);
        for (int s = 0; s < n; s++) begin
            if (member_shadow[s].vid == vid) begin
                return s;
            end
        end
        return -1;
    endfunction

    // expected result of one command; a write also updates the shadow table
    function automatic t_out_item vlan_verdict(t_in_item c);
        t_out_item res;
        logic [VID_W-1:0] want;
        logic use_pvid;
        int slot;
        res = '0;
        case (c.cmd)
            CMD_WRITE: begin
                member_shadow[c.entry_index].vid        = c.vlan_id;
                member_shadow[c.entry_index].untagged   = c.entry_untagged;
                member_shadow[c.entry_index].forwarding = c.entry_forwarding;
                member_shadow[c.entry_index].tunnel     = c.entry_tunnel;
            end
            CMD_INGRESS: begin
                if (cfg_bridge && cfg_filter) begin
                    // missing tag or wrong tag kind falls back to the pvid
                    use_pvid = !c.tag_present || (c.tag_is_ad != cfg_proto_ad);
                    want = use_pvid ? cfg_pvid : c.vlan_id;
                    slot = find_member(want);
                    if ((use_pvid && cfg_pvid == '0) || slot < 0) begin
                        res.verdict = VERDICT_DROP;
                    end else begin
                        res.verdict    = VERDICT_VALID;
                        res.result_vid = want;
                    end
                end
            end
            CMD_EGRESS: begin
                if (cfg_bridge && cfg_filter) begin
                    slot = find_member(c.vlan_id);
                    if (slot < 0) begin
                        res.verdict = VERDICT_DROP;
                    end else if (!member_shadow[slot].untagged) begin
                        res.verdict         = VERDICT_VALID;
                        res.result_vid      = c.vlan_id;
                        res.out_tag_present = 1'b1;
                        res.out_tag_is_ad   = cfg_proto_ad;
                    end
                end
            end
            CMD_QUERY: begin
                if (!cfg_table) begin
                    res.is_forwarding = 1'b1;
                end else begin
                    slot = find_member(c.vlan_id);
                    if (slot >= 0) begin
                        res.is_forwarding = member_shadow[slot].forwarding;
                        res.has_tunnel    = member_shadow[slot].tunnel;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [VID_W-1:0] exp_v,
                                        logic [VID_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            err_count++;
        end
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] op, logic [VID_W-1:0] vid,
                                          logic tp, logic tad, logic [SLOT_W-1:0] idx,
                                          logic ut, logic fw, logic tn);
        t_in_item c;
        c.cmd              = op;
        c.vlan_id          = vid;
        c.tag_present      = tp;
        c.tag_is_ad        = tad;
        c.entry_index      = idx;
        c.entry_untagged   = ut;
        c.entry_forwarding = fw;
        c.entry_tunnel     = tn;
        return c;
    endfunction

    // mostly vids from a small pool so lookups hit the table
    function automatic t_in_item random_cmd();
        t_in_item c;
        int unsigned roll;
        roll = $urandom_range(99);
        c.cmd = (roll < 15) ? CMD_WRITE : (roll < 50) ? CMD_INGRESS :
                (roll < 80) ? CMD_EGRESS : CMD_QUERY;
        if ($urandom_range(99) < 80) begin
            c.vlan_id = vid_pool[$urandom_range(7)];
        end else begin
            c.vlan_id = VID_W'($urandom_range(4095));
        end
        c.tag_present      = ($urandom_range(99) < 75);
        c.tag_is_ad        = 1'($urandom_range(1));
        c.entry_index      = SLOT_W'($urandom_range(N_SLOTS - 1));
        c.entry_untagged   = 1'($urandom_range(1));
        c.entry_forwarding = 1'($urandom_range(1));
        c.entry_tunnel     = 1'($urandom_range(1));
        return c;
    endfunction

    // one register write transfer; the shadow copy follows at the handshake
    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BRIDGE_PRESENT:    cfg_bridge   = val[0];
            REG_FILTERING_ENABLED: cfg_filter   = val[0];
            REG_PROTO_IS_AD:       cfg_proto_ad = val[0];
            REG_PORT_DEFAULT_VID:  cfg_pvid     = val[VID_W-1:0];
            REG_ENTRY_COUNT:       cfg_count    = val[CNT_W-1:0];
            REG_TABLE_PRESENT:     cfg_table    = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic br, logic flt, logic ad, logic [VID_W-1:0] pvid,
                              logic [CNT_W-1:0] cnt, logic tbl);
        write_reg(REG_BRIDGE_PRESENT, CFG_D_W'(br));
        write_reg(REG_FILTERING_ENABLED, CFG_D_W'(flt));
        write_reg(REG_PROTO_IS_AD, CFG_D_W'(ad));
        write_reg(REG_PORT_DEFAULT_VID, CFG_D_W'(pvid));
        write_reg(REG_ENTRY_COUNT, CFG_D_W'(cnt));
        write_reg(REG_TABLE_PRESENT, CFG_D_W'(tbl));
        @(negedge i_clk);
    endtask

    // every command gives a result, so an empty result queue means idle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_pending.size() != 0 || in_valid || verdict_q.size() != 0);
    endtask

    // command driver: predicts at each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                verdict_q.push_back(vlan_verdict(in_data));
                cmd_count[in_data.cmd]++;
            end
            if (!in_valid || !o_in_stall) begin
                if (cmd_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_data  <= cmd_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stall and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    $error("result transfer with no command outstanding: %p", o_out_data);
                    err_count++;
                end else begin
                    exp_res = verdict_q.pop_front();
                    check_field("verdict", VID_W'(exp_res.verdict),
                                VID_W'(o_out_data.verdict));
                    check_field("result_vid", exp_res.result_vid, o_out_data.result_vid);
                    check_field("out_tag_present", VID_W'(exp_res.out_tag_present),
                                VID_W'(o_out_data.out_tag_present));
                    check_field("out_tag_is_ad", VID_W'(exp_res.out_tag_is_ad),
                                VID_W'(o_out_data.out_tag_is_ad));
                    check_field("is_forwarding", VID_W'(exp_res.is_forwarding),
                                VID_W'(o_out_data.is_forwarding));
                    check_field("has_tunnel", VID_W'(exp_res.has_tunnel),
                                VID_W'(o_out_data.has_tunnel));
                    if (exp_res.verdict <= VERDICT_DROP) begin
                        verdict_count[exp_res.verdict]++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // long hold so the block fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", verdict_q.size());
        $display("tb_top failed");
        $finish;
    end

    initial begin
        logic             br, flt;
        logic [VID_W-1:0] pvid;
        logic [CNT_W-1:0] cnt;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: no bridge and no table, so everything passes
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd100, 1, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_EGRESS, 12'd100, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_QUERY, 12'd4095, 0, 0, 0, 0, 0, 0));
        // slot 3 repeats vid 100 with other flags: first match must win
        cmd_pending.push_back(make_cmd(CMD_WRITE, 12'd5, 0, 0, 0, 0, 1, 0));
        cmd_pending.push_back(make_cmd(CMD_WRITE, 12'd100, 0, 0, 1, 1, 0, 1));
        cmd_pending.push_back(make_cmd(CMD_WRITE, 12'd4095, 1, 1, 2, 1, 1, 1));
        cmd_pending.push_back(make_cmd(CMD_WRITE, 12'd100, 0, 0, 3, 0, 1, 0));
        cmd_pending.push_back(make_cmd(CMD_WRITE, 12'd0, 1, 1, 15, 1, 1, 1));
        wait_idle();

        // filtering on, 802.1Q, pvid 5
        set_config(1, 1, 0, 12'd5, 5'd4, 1);
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd100, 1, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd7, 1, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd100, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd100, 1, 1, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd4095, 1, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_EGRESS, 12'd5, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_EGRESS, 12'd100, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_EGRESS, 12'd9, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_QUERY, 12'd100, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_QUERY, 12'd4095, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_QUERY, 12'd3, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // 802.1AD without pvid: fallback drops, tagged egress is AD
        set_config(1, 1, 1, 12'd0, 5'd4, 1);
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd5, 0, 1, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd100, 1, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd4095, 1, 1, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_EGRESS, 12'd5, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // bridge present but filtering off
        set_config(1, 0, 1, 12'd5, 5'd4, 1);
        cmd_pending.push_back(make_cmd(CMD_INGRESS, 12'd100, 1, 1, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(CMD_EGRESS, 12'd5, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // random part: fill every slot before any count above four
        vid_pool[0] = 12'd0;
        vid_pool[1] = 12'd4095;
        vid_pool[2] = 12'd5;
        vid_pool[3] = 12'd100;
        for (int k = 4; k < 8; k++) begin
            vid_pool[k] = VID_W'($urandom_range(1, 4094));
        end
        for (int s = 0; s < N_SLOTS; s++) begin
            cmd_pending.push_back(make_cmd(CMD_WRITE, vid_pool[$urandom_range(7)], 0, 0,
                                           SLOT_W'(s), 1'($urandom_range(1)),
                                           1'($urandom_range(1)), 1'($urandom_range(1))));
        end
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            br   = (ph == 2) ? 1'b0 : ($urandom_range(9) != 0);
            flt  = (ph == 3) ? 1'b0 : ($urandom_range(9) != 0);
            pvid = (ph == 0) ? 12'd4095 : (ph == 1) ? 12'd0 :
                   ($urandom_range(3) == 0) ? 12'd0 : vid_pool[$urandom_range(7)];
            case (ph)
                0:       cnt = 5'd16;
                1:       cnt = 5'd31;
                2:       cnt = 5'd0;
                3:       cnt = 5'd1;
                4:       cnt = 5'd17;
                default: cnt = CNT_W'($urandom_range(31));
            endcase
            set_config(br, flt, 1'($urandom_range(1)), pvid, cnt,
                       (ph == 4) ? 1'b0 : ($urandom_range(3) != 0));
            // one phase runs without any idling on either side
            calm = (ph == 6);
            repeat (PHASE_ITEMS) cmd_pending.push_back(random_cmd());
            wait_idle();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d writes, %0d ingress, %0d egress, %0d queries",
                 cmd_count[CMD_WRITE], cmd_count[CMD_INGRESS], cmd_count[CMD_EGRESS],
                 cmd_count[CMD_QUERY]);
        $display("verdicts seen: %0d pass, %0d valid, %0d drop; %0d field mismatches",
                 verdict_count[VERDICT_PASS], verdict_count[VERDICT_VALID],
                 verdict_count[VERDICT_DROP], err_count);
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pvmf_pkg.sv
rtl/pvmf_ram.sv
rtl/port_vlan_membership_filter_unit.sv
bench/tb_top.sv
